FILE: rtl/ethl4_pkg.sv
// Shared types and constants for the Ethernet/IPv4/L4 header parser.
package ethl4_pkg;

   localparam int unsigned MAX_FRAME_BYTES_DEF = 65536;
   localparam logic [15:0] ETHERTYPE_IPV4      = 16'h0800;
   localparam int unsigned ETH_HEADER_BYTES    = 14;
   localparam logic [7:0]  PROTO_TCP           = 8'd6;
   localparam logic [7:0]  PROTO_UDP           = 8'd17;
   localparam logic [7:0]  FLAG_MASK           = 8'h3F;
   localparam logic [7:0]  NIBBLE_MASK         = 8'h0F;
   localparam logic [31:0] COUNT_MAX           = 32'hFFFF_FFFF;
   localparam int unsigned RSP_DATA_W          = 192;

   typedef enum logic [1:0] {
      CLASS_NON_IP   = 2'd0,
      CLASS_TCP      = 2'd1,
      CLASS_UDP      = 2'd2,
      CLASS_OTHER_IP = 2'd3
   } class_type;

   typedef struct packed {
      logic [5:0]  tcp_flag_bits;
      logic [15:0] dest_port;
      logic [15:0] source_port;
      logic [31:0] dest_address;
      logic [31:0] source_address;
      logic [7:0]  ip_protocol;
      logic [7:0]  time_to_live;
      logic [15:0] ip_total_length;
      logic [3:0]  ip_header_words;
      logic [15:0] ether_type;
   } fields_type;

endpackage

FILE: rtl/ethl4_capture.sv
// Byte position tracking and per-frame header field capture.
module ethl4_capture #(
   parameter int unsigned MAX_FRAME_BYTES = ethl4_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             frame_byte,
   input  logic                   last_byte,
   output ethl4_pkg::fields_type  fields_view
);

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [POS_W-1:0]      pos_ff, pos_in;
   ethl4_pkg::fields_type fields_ff, fields_in, nxt;
   logic                  in_range;
   logic [POS_W-1:0]      l4;

   assign in_range = pos_ff < POS_W'(MAX_FRAME_BYTES);

   always_comb begin
      nxt = fields_ff;
      l4  = '0;
      if (in_range) begin
         if (pos_ff == POS_W'(12)) nxt.ether_type[15:8] = frame_byte;
         if (pos_ff == POS_W'(13)) nxt.ether_type[7:0]  = frame_byte;
         if (pos_ff == POS_W'(14)) nxt.ip_header_words =
            4'(frame_byte & ethl4_pkg::NIBBLE_MASK);
         if (pos_ff == POS_W'(16)) nxt.ip_total_length[15:8] = frame_byte;
         if (pos_ff == POS_W'(17)) nxt.ip_total_length[7:0]  = frame_byte;
         if (pos_ff == POS_W'(22)) nxt.time_to_live = frame_byte;
         if (pos_ff == POS_W'(23)) nxt.ip_protocol  = frame_byte;
         if (pos_ff == POS_W'(26)) nxt.source_address[31:24] = frame_byte;
         if (pos_ff == POS_W'(27)) nxt.source_address[23:16] = frame_byte;
         if (pos_ff == POS_W'(28)) nxt.source_address[15:8]  = frame_byte;
         if (pos_ff == POS_W'(29)) nxt.source_address[7:0]   = frame_byte;
         if (pos_ff == POS_W'(30)) nxt.dest_address[31:24]   = frame_byte;
         if (pos_ff == POS_W'(31)) nxt.dest_address[23:16]   = frame_byte;
         if (pos_ff == POS_W'(32)) nxt.dest_address[15:8]    = frame_byte;
         if (pos_ff == POS_W'(33)) nxt.dest_address[7:0]     = frame_byte;
         l4 = POS_W'(ethl4_pkg::ETH_HEADER_BYTES) + POS_W'({nxt.ip_header_words, 2'b00});
         if (pos_ff == l4)               nxt.source_port[15:8] = frame_byte;
         if (pos_ff == l4 + POS_W'(1))   nxt.source_port[7:0]  = frame_byte;
         if (pos_ff == l4 + POS_W'(2))   nxt.dest_port[15:8]   = frame_byte;
         if (pos_ff == l4 + POS_W'(3))   nxt.dest_port[7:0]    = frame_byte;
         if (pos_ff == l4 + POS_W'(13))  nxt.tcp_flag_bits =
            6'(frame_byte & ethl4_pkg::FLAG_MASK);
      end
   end

   assign fields_view = nxt;

   always_comb begin
      pos_in    = pos_ff;
      fields_in = fields_ff;
      if (advance) begin
         if (last_byte) begin
            pos_in    = '0;
            fields_in = '0;
         end else begin
            fields_in = nxt;
            if (in_range) pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         fields_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         fields_ff <= fields_in;
      end
   end

endmodule

FILE: rtl/ethl4_counter.sv
// Saturating per-class frame counters.
module ethl4_counter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  bump,
   input  ethl4_pkg::class_type  frame_class,
   output logic [31:0]           count_next
);

   logic [31:0] count_ff [4];
   logic [31:0] count_in [4];
   logic [31:0] cur;

   assign cur        = count_ff[frame_class];
   assign count_next = (cur == ethl4_pkg::COUNT_MAX) ? cur : cur + 32'd1;

   always_comb begin
      for (int i = 0; i < 4; i++) count_in[i] = count_ff[i];
      if (bump) count_in[frame_class] = count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) count_ff[i] <= '0;
      end else begin
         for (int i = 0; i < 4; i++) count_ff[i] <= count_in[i];
      end
   end

endmodule

FILE: rtl/ethernet_ip_l4_header_parser.sv
// Top level of the Ethernet II / IPv4 / TCP / UDP header parser.
// Takes one frame byte per cycle on the req_ stream, tlast marking the final byte, and
// returns one result word per frame on the rsp_ stream from a result register loaded as
// the capture stage takes that final byte: frame class in tuser, captured header fields and the
// saturating count of frames of that class in tdata. Bytes flow at one per cycle through an
// input register and a capture stage; req_tready drops only while a final byte waits in the
// input register behind a result that has not yet been taken. MAX_FRAME_BYTES sets where the
// byte position stops counting; bytes beyond it load nothing.
module ethernet_ip_l4_header_parser #(
   parameter int unsigned MAX_FRAME_BYTES = ethl4_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] frame_byte
   input  logic                             req_tlast,  // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] ether_type, [19:16] ip_header_words, [35:20] ip_total_length,
   // [43:36] time_to_live, [51:44] ip_protocol, [83:52] source_address,
   // [115:84] dest_address, [131:116] source_port, [147:132] dest_port,
   // [153:148] tcp_flag_bits, [185:154] class_count, [191:186] zero
   output logic [ethl4_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                       rsp_tuser   // [1:0] frame_class
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  advance, load;
   ethl4_pkg::fields_type view, shown;
   ethl4_pkg::class_type  cls;
   logic                  is_ip;
   logic [31:0]           count_next;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ethl4_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   ethl4_pkg::class_type  rsp_class_ff;

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign load       = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ethl4_capture #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .frame_byte (in_byte_ff),
      .last_byte  (in_last_ff),
      .fields_view(view)
   );

   always_comb begin
      is_ip = view.ether_type == ethl4_pkg::ETHERTYPE_IPV4;
      if (!is_ip)                                  cls = ethl4_pkg::CLASS_NON_IP;
      else if (view.ip_protocol == ethl4_pkg::PROTO_TCP) cls = ethl4_pkg::CLASS_TCP;
      else if (view.ip_protocol == ethl4_pkg::PROTO_UDP) cls = ethl4_pkg::CLASS_UDP;
      else                                         cls = ethl4_pkg::CLASS_OTHER_IP;
   end

   ethl4_counter u_counter (
      .clock      (clock),
      .reset      (reset),
      .bump       (load),
      .frame_class(cls),
      .count_next (count_next)
   );

   always_comb begin
      shown = view;
      if (!is_ip) begin
         shown.ip_header_words = '0;
         shown.ip_total_length = '0;
         shown.time_to_live    = '0;
         shown.ip_protocol     = '0;
         shown.source_address  = '0;
         shown.dest_address    = '0;
      end
      if (cls != ethl4_pkg::CLASS_TCP && cls != ethl4_pkg::CLASS_UDP) begin
         shown.source_port = '0;
         shown.dest_port   = '0;
      end
      if (cls != ethl4_pkg::CLASS_TCP) shown.tcp_flag_bits = '0;
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff  <= {6'd0, count_next, shown};
         rsp_class_ff <= cls;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_class_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load))
      else $error("result raised without a final byte");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[185:154] != 32'd0))
      else $error("class count zero on a result");

   a_flags_tcp_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_class_ff != ethl4_pkg::CLASS_TCP) |->
         (rsp_data_ff[153:148] == 6'd0))
      else $error("TCP flags on a non-TCP result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a held result");

endmodule
